/* hdl/rsi_pkg.sv */
package rsi_pkg;

	localparam int CRD_W     = 32;
	localparam int DIF_W     = CRD_W + 1;
	localparam int PRD_W     = DIF_W + CRD_W;
	localparam int CRS_W     = PRD_W + 1;
	localparam int MAG_W     = CRS_W - 1;
	localparam int Q_W       = DIF_W;
	localparam int DIV_STEPS = Q_W;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [DATA_W-1:0] EPS_RESET = 32'd512;
	// Register select, taken from paddr bit 2.
	localparam logic REG_EPS = 1'b0;

	typedef logic signed [CRD_W-1:0] crd_t;
	typedef logic signed [DIF_W-1:0] dif_t;

	typedef struct packed {
		crd_t sx;
		crd_t sy;
		crd_t ex;
		crd_t ey;
		crd_t ox;
		crd_t oy;
		crd_t rx;
		crd_t ry;
	} in_item_t;

	typedef struct packed {
		crd_t sx;
		crd_t sy;
		crd_t ox;
		crd_t oy;
		crd_t rx;
		crd_t ry;
	} geo_t;

	typedef struct packed {
		geo_t             g;
		logic             miss;
		logic             negx;
		logic             negy;
		logic [Q_W-1:0]   magx;
		logic [Q_W-1:0]   magy;
		logic [MAG_W-1:0] num;
		logic [MAG_W-1:0] den;
		logic [Q_W-1:0]   qx;
		logic [Q_W-1:0]   qy;
		logic [MAG_W-1:0] remx;
		logic [MAG_W-1:0] remy;
	} div_t;

	typedef struct packed {
		logic hit;
		crd_t x;
		crd_t y;
	} hit_t;

endpackage

/* hdl/rsi_if.sv */
interface rsi_in_if import rsi_pkg::*; ();
	logic valid;
	logic ready;
	crd_t seg_start_x;
	crd_t seg_start_y;
	crd_t seg_end_x;
	crd_t seg_end_y;
	crd_t ray_origin_x;
	crd_t ray_origin_y;
	crd_t ray_dir_x;
	crd_t ray_dir_y;

	modport source (output valid, output seg_start_x, output seg_start_y, output seg_end_x,
		output seg_end_y, output ray_origin_x, output ray_origin_y, output ray_dir_x,
		output ray_dir_y, input ready);
	modport sink (input valid, input seg_start_x, input seg_start_y, input seg_end_x,
		input seg_end_y, input ray_origin_x, input ray_origin_y, input ray_dir_x,
		input ray_dir_y, output ready);
endinterface

interface rsi_out_if import rsi_pkg::*; ();
	logic valid;
	logic ready;
	logic hit;
	crd_t hit_x;
	crd_t hit_y;

	modport source (output valid, output hit, output hit_x, output hit_y, input ready);
	modport sink (input valid, input hit, input hit_x, input hit_y, output ready);
endinterface

/* hdl/rsi_cfg.sv */
module rsi_cfg import rsi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [DATA_W-1:0] eps
);

	logic [DATA_W-1:0] eps_q;

	assign pready = 1'b1;
	assign eps    = eps_q;
	assign prdata = (paddr[2] == REG_EPS) ? eps_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_EPS) begin
			eps_q <= pwdata;
		end
	end

endmodule

/* hdl/rsi_cross.sv */
module rsi_cross import rsi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  in_item_t          in_d,
	input  logic [DATA_W-1:0] eps,
	output logic              out_v,
	output div_t              out_d
);

	typedef struct packed {
		geo_t g;
		dif_t dx;
		dif_t dy;
	} front_t;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	front_t f_s1, f_s2, f_s3, f_s4;
	dif_t wx_s1, wy_s1;
	logic signed [PRD_W-1:0] pd1_s2, pd2_s2, pn1_s2, pn2_s2;
	logic signed [CRS_W-1:0] den_s3, num_s3;
	logic [CRS_W-1:0] den_s4, num_s4;
	div_t d_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1.g  <= '{sx: in_d.sx, sy: in_d.sy, ox: in_d.ox, oy: in_d.oy,
				rx: in_d.rx, ry: in_d.ry};
			f_s1.dx <= DIF_W'(in_d.ex) - DIF_W'(in_d.sx);
			f_s1.dy <= DIF_W'(in_d.ey) - DIF_W'(in_d.sy);
			wx_s1   <= DIF_W'(in_d.ox) - DIF_W'(in_d.sx);
			wy_s1   <= DIF_W'(in_d.oy) - DIF_W'(in_d.sy);

			f_s2   <= f_s1;
			pd1_s2 <= f_s1.dx * f_s1.g.ry;
			pd2_s2 <= f_s1.dy * f_s1.g.rx;
			pn1_s2 <= wx_s1 * f_s1.g.ry;
			pn2_s2 <= wy_s1 * f_s1.g.rx;

			f_s3   <= f_s2;
			den_s3 <= CRS_W'(pd1_s2) - CRS_W'(pd2_s2);
			num_s3 <= CRS_W'(pn1_s2) - CRS_W'(pn2_s2);

			// Flip both cross products so that the denominator is positive.
			f_s4   <= f_s3;
			den_s4 <= den_s3[CRS_W-1] ? CRS_W'(-den_s3) : CRS_W'(den_s3);
			num_s4 <= den_s3[CRS_W-1] ? CRS_W'(-num_s3) : CRS_W'(num_s3);

			d_s5.g    <= f_s4.g;
			d_s5.miss <= (den_s4 <= CRS_W'(eps)) || num_s4[CRS_W-1] || (num_s4 >= den_s4);
			d_s5.negx <= f_s4.dx[DIF_W-1];
			d_s5.negy <= f_s4.dy[DIF_W-1];
			d_s5.magx <= f_s4.dx[DIF_W-1] ? Q_W'(-f_s4.dx) : Q_W'(f_s4.dx);
			d_s5.magy <= f_s4.dy[DIF_W-1] ? Q_W'(-f_s4.dy) : Q_W'(f_s4.dy);
			d_s5.num  <= num_s4[MAG_W-1:0];
			d_s5.den  <= den_s4[MAG_W-1:0];
			d_s5.qx   <= '0;
			d_s5.qy   <= '0;
			d_s5.remx <= '0;
			d_s5.remy <= '0;
		end
	end

	assign out_v = v_s5;
	assign out_d = d_s5;

endmodule

/* hdl/rsi_div_stage.sv */
module rsi_div_stage import rsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_v,
	input  div_t in_d,
	output logic out_v,
	output div_t out_d
);

	// One step of |d| * num / den, taking the next bit of |d| from the top.
	// The running remainder stays below den, so the new quotient digit is 0, 1 or 2.
	function automatic logic [Q_W+MAG_W-1:0] div_step(logic [Q_W-1:0] q,
		logic [MAG_W-1:0] rem, logic b, logic [MAG_W-1:0] num, logic [MAG_W-1:0] den);
		logic [MAG_W+2:0] t, t1, t2;
		logic [Q_W:0]     qq;
		logic [Q_W-1:0]   qn;
		logic [MAG_W-1:0] rn;
		t  = {2'b00, rem, 1'b0} + (b ? (MAG_W+3)'(num) : '0);
		t1 = t - (MAG_W+3)'(den);
		t2 = t - {2'b00, den, 1'b0};
		qq = {q, 1'b0};
		if (!t2[MAG_W+2]) begin
			qn = Q_W'(qq + (Q_W+1)'(2));
			rn = t2[MAG_W-1:0];
		end else if (!t1[MAG_W+2]) begin
			qn = Q_W'(qq + (Q_W+1)'(1));
			rn = t1[MAG_W-1:0];
		end else begin
			qn = Q_W'(qq);
			rn = t[MAG_W-1:0];
		end
		return {qn, rn};
	endfunction

	logic [Q_W+MAG_W-1:0] nx, ny;
	logic v_q;
	div_t d_n;
	div_t d_q;

	assign nx = div_step(in_d.qx, in_d.remx, in_d.magx[Q_W-1], in_d.num, in_d.den);
	assign ny = div_step(in_d.qy, in_d.remy, in_d.magy[Q_W-1], in_d.num, in_d.den);

	always_comb begin
		d_n      = in_d;
		d_n.magx = {in_d.magx[Q_W-2:0], 1'b0};
		d_n.magy = {in_d.magy[Q_W-2:0], 1'b0};
		d_n.qx   = nx[Q_W+MAG_W-1:MAG_W];
		d_n.qy   = ny[Q_W+MAG_W-1:MAG_W];
		d_n.remx = nx[MAG_W-1:0];
		d_n.remy = ny[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= d_n;
		end
	end

	assign out_v = v_q;
	assign out_d = d_q;

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_v && !out_d.miss |-> (out_d.remx < out_d.den) && (out_d.remy < out_d.den))
		else $error("divider remainder not below denominator");

endmodule

/* hdl/rsi_point.sv */
module rsi_point import rsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_v,
	input  div_t in_d,
	output logic out_v,
	output hit_t out_d
);

	typedef struct packed {
		logic miss;
		crd_t hx;
		crd_t hy;
		crd_t ox;
		crd_t oy;
		crd_t rx;
		crd_t ry;
	} pt_t;

	logic v_s1, v_s2, v_s3, v_s4;
	pt_t p_s1, p_s2, p_s3;
	dif_t ex_s2, ey_s2;
	logic signed [PRD_W-1:0] mx_s3, my_s3;
	hit_t h_s4;

	logic fracx, fracy;
	logic signed [Q_W+1:0] qsx, qsy, flx, fly, basex, basey, hx, hy;
	logic signed [CRS_W-1:0] dot;

	// Truncate start + d * t toward zero, from the floor of |d| * t and its remainder.
	always_comb begin
		fracx = |in_d.remx;
		fracy = |in_d.remy;
		qsx   = signed'({2'b00, in_d.qx});
		qsy   = signed'({2'b00, in_d.qy});
		flx   = in_d.negx ? -qsx - signed'((Q_W+2)'(fracx)) : qsx;
		fly   = in_d.negy ? -qsy - signed'((Q_W+2)'(fracy)) : qsy;
		basex = (Q_W+2)'(in_d.g.sx) + flx;
		basey = (Q_W+2)'(in_d.g.sy) + fly;
		hx    = (fracx && basex[Q_W+1]) ? basex + signed'((Q_W+2)'(1)) : basex;
		hy    = (fracy && basey[Q_W+1]) ? basey + signed'((Q_W+2)'(1)) : basey;
	end

	assign dot = CRS_W'(mx_s3) + CRS_W'(my_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= '{miss: in_d.miss, hx: CRD_W'(hx), hy: CRD_W'(hy), ox: in_d.g.ox,
				oy: in_d.g.oy, rx: in_d.g.rx, ry: in_d.g.ry};

			p_s2  <= p_s1;
			ex_s2 <= DIF_W'(p_s1.hx) - DIF_W'(p_s1.ox);
			ey_s2 <= DIF_W'(p_s1.hy) - DIF_W'(p_s1.oy);

			p_s3  <= p_s2;
			mx_s3 <= ex_s2 * p_s2.rx;
			my_s3 <= ey_s2 * p_s2.ry;

			// The hit must lie strictly ahead of the ray origin.
			if (!p_s3.miss && !dot[CRS_W-1] && dot != '0) begin
				h_s4 <= '{hit: 1'b1, x: p_s3.hx, y: p_s3.hy};
			end else begin
				h_s4 <= '0;
			end
		end
	end

	assign out_v = v_s4;
	assign out_d = h_s4;

endmodule

/* hdl/ray_segment_intersect_2d_top.sv */
// Channel  Interface        Direction  Content
// item     rsi_in_if.sink   in         segment end points, ray origin and direction
// result   rsi_out_if.source out       hit flag and Q16.16 hit point
// config   APB              in/out     parallel_epsilon at byte address 0
//
// One item per cycle while item.ready is high; a result passes through the cross product
// stages, 33 divider steps (each taking the next bit of |d| for |d| * t), the hit point and
// ahead test stages, and the output register.
// Reset clears every valid bit and sets parallel_epsilon to 512.
// A stalled result is held in the output register and one more in a skid register;
// item.ready is low exactly while the skid register is full.
module ray_segment_intersect_2d_top import rsi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	rsi_in_if.sink            item,
	rsi_out_if.source         result
);

	logic [DATA_W-1:0] eps;
	logic en;
	in_item_t in_d;
	div_t dd [DIV_STEPS+1];
	logic dv [DIV_STEPS+1];
	logic pv, take;
	hit_t pd;
	logic out_v_q, skid_v_q;
	hit_t out_q, skid_q;

	rsi_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .eps
	);

	assign en         = !skid_v_q;
	assign item.ready = en;

	assign in_d = '{sx: item.seg_start_x, sy: item.seg_start_y, ex: item.seg_end_x,
		ey: item.seg_end_y, ox: item.ray_origin_x, oy: item.ray_origin_y,
		rx: item.ray_dir_x, ry: item.ray_dir_y};

	rsi_cross u_cross (
		.clk, .arst_n, .en, .in_v(item.valid), .in_d, .eps, .out_v(dv[0]), .out_d(dd[0])
	);

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		rsi_div_stage u_step (
			.clk, .arst_n, .en, .in_v(dv[i]), .in_d(dd[i]), .out_v(dv[i+1]), .out_d(dd[i+1])
		);
	end

	rsi_point u_point (
		.clk, .arst_n, .en, .in_v(dv[DIV_STEPS]), .in_d(dd[DIV_STEPS]), .out_v(pv),
		.out_d(pd)
	);

	assign take = en && pv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || result.ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= take;
			end
		end else if (take) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || result.ready) begin
			out_q <= skid_v_q ? skid_q : pd;
		end else if (take) begin
			skid_q <= pd;
		end
	end

	assign result.valid = out_v_q;
	assign result.hit   = out_q.hit;
	assign result.hit_x = out_q.x;
	assign result.hit_y = out_q.y;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full while output register empty");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_q.hit |-> out_q.x == '0 && out_q.y == '0)
		else $error("miss result with nonzero point");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !result.ready && take |=> skid_v_q)
		else $error("result lost while output stalled");

endmodule

/* sim/tb_top.sv */
module tb_top import rsi_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [127:0] wide_t;

	localparam logic [ADDR_W-1:0] EPS_ADDR   = 3'd0;
	localparam logic [ADDR_W-1:0] SPARE_ADDR = 3'd4;
	localparam crd_t ONE        = 32'sh0001_0000;
	localparam int   STALL_LIMIT = 5000;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	rsi_in_if  item ();
	rsi_out_if result ();

	ray_segment_intersect_2d_top dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item(item.sink), .result(result.source)
	);

	logic [31:0] eps_copy;
	hit_t        hit_queue[$];
	int          errors;
	bit          idle_on;
	int          quiet_cycles;
	int          stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	// Trunc of s + d * num / den, with 0 <= num < den.
	function automatic wide_t point_on_segment(wide_t s, wide_t d, wide_t num, wide_t den);
		wide_t p, q, rm;
		p  = d * num;
		q  = p / den;
		rm = p % den;
		if (rm != 0 && p < 0)
			q = q - 1;
		q = s + q;
		if (rm != 0 && q < 0)
			q = q + 1;
		return q;
	endfunction

	function automatic hit_t predict_hit(in_item_t it, logic [31:0] eps);
		wide_t sx, sy, ex, ey, ox, oy, rx, ry;
		wide_t dx, dy, wx, wy, den, num, hx, hy, dot, eps_w, mag;
		hit_t  r;
		r = '0;
		sx = it.sx; sy = it.sy; ex = it.ex; ey = it.ey;
		ox = it.ox; oy = it.oy; rx = it.rx; ry = it.ry;
		dx = ex - sx; dy = ey - sy;
		wx = ox - sx; wy = oy - sy;
		den = dx * ry - dy * rx;
		eps_w = '0;
		eps_w[31:0] = eps;
		mag = den < 0 ? -den : den;
		if (mag <= eps_w)
			return r;
		num = wx * ry - wy * rx;
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		if (num < 0 || num >= den)
			return r;
		hx = point_on_segment(sx, dx, num, den);
		hy = point_on_segment(sy, dy, num, den);
		dot = (hx - ox) * rx + (hy - oy) * ry;
		if (dot <= 0)
			return r;
		r.hit = 1'b1;
		r.x   = hx[31:0];
		r.y   = hy[31:0];
		return r;
	endfunction

	// Input side: predict on every transfer. Output side: compare with the oldest.
	always @(posedge clk) begin
		hit_t got, exp_hit;
		if (arst_n) begin
			if (item.valid && item.ready)
				hit_queue.push_back(predict_hit({item.seg_start_x, item.seg_start_y,
					item.seg_end_x, item.seg_end_y, item.ray_origin_x, item.ray_origin_y,
					item.ray_dir_x, item.ray_dir_y}, eps_copy));
			if (result.valid && result.ready) begin
				got = {result.hit, result.hit_x, result.hit_y};
				if (hit_queue.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					exp_hit = hit_queue.pop_front();
					if (got.hit !== exp_hit.hit)
						report_mismatch($sformatf("hit %0b, expected %0b", got.hit, exp_hit.hit));
					if (got.x !== exp_hit.x)
						report_mismatch($sformatf("hit_x %h, expected %h", got.x, exp_hit.x));
					if (got.y !== exp_hit.y)
						report_mismatch($sformatf("hit_y %h, expected %h", got.y, exp_hit.y));
				end
			end
			if ((item.valid && item.ready) || (result.valid && result.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	// Receiver back-pressure in random bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 13);
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
		end
	end

	task automatic send_item(input in_item_t it);
		item.valid        <= 1'b1;
		item.seg_start_x  <= it.sx;
		item.seg_start_y  <= it.sy;
		item.seg_end_x    <= it.ex;
		item.seg_end_y    <= it.ey;
		item.ray_origin_x <= it.ox;
		item.ray_origin_y <= it.oy;
		item.ray_dir_x    <= it.rx;
		item.ray_dir_y    <= it.ry;
		do @(posedge clk); while (!item.ready);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Registers change only once the pipeline has emptied.
	task automatic wait_idle();
		item.valid <= 1'b0;
		@(posedge clk);
		while (hit_queue.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		logic [31:0] rd;
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr == EPS_ADDR)
			eps_copy = data;
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		rd = prdata;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0;
		if (addr == EPS_ADDR && rd !== data)
			report_mismatch($sformatf("epsilon read %h, expected %h", rd, data));
	endtask

	function automatic crd_t rand_coord();
		case ($urandom_range(0, 3))
			0: return crd_t'($urandom);
			1: return crd_t'($urandom_range(0, 32'h3FFF)) - 32'sh2000;
			2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return crd_t'($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000;
		endcase
	endfunction

	// A segment and a ray aimed at a random point from its start to past its end, sometimes reversed or off.
	function automatic in_item_t aimed_item(int span);
		in_item_t it;
		longint   k, tx, ty;
		it.sx = crd_t'($urandom_range(0, 2 * span)) - span;
		it.sy = crd_t'($urandom_range(0, 2 * span)) - span;
		it.ex = crd_t'($urandom_range(0, 2 * span)) - span;
		it.ey = crd_t'($urandom_range(0, 2 * span)) - span;
		it.ox = crd_t'($urandom_range(0, 2 * span)) - span;
		it.oy = crd_t'($urandom_range(0, 2 * span)) - span;
		k  = $urandom_range(0, 300);
		tx = longint'(it.sx) + (longint'(it.ex) - it.sx) * k / 256;
		ty = longint'(it.sy) + (longint'(it.ey) - it.sy) * k / 256;
		it.rx = crd_t'(tx - it.ox);
		it.ry = crd_t'(ty - it.oy);
		if ($urandom_range(0, 5) == 0) begin
			it.rx = -it.rx;
			it.ry = -it.ry;
		end
		if ($urandom_range(0, 5) == 0)
			it.rx = it.rx + crd_t'($urandom_range(0, 15)) - 8;
		return it;
	endfunction

	task automatic test_directed();
		send_item('{0, -ONE, 0, ONE, -ONE, 0, ONE, 0});
		send_item('{0, 0, 0, ONE, -ONE, 0, ONE, 0});
		send_item('{0, 0, 0, ONE, -ONE, ONE, ONE, 0});
		send_item('{0, -ONE, 0, ONE, ONE, 0, ONE, 0});
		send_item('{0, -ONE, 0, ONE, 0, 0, ONE, 0});
		send_item('{ONE, ONE, ONE, ONE, 0, 0, ONE, 0});
		send_item('{0, -ONE, 0, ONE, -ONE, 0, 0, 0});
		send_item('{0, 0, ONE, 0, 0, ONE, ONE, 0});
		send_item('{-3, -7, 5, 9, -11, 2, 7, 1});
		send_item('{-ONE, -ONE, ONE, ONE, -ONE, ONE, 3, -7});
		send_item('{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000});
		send_item('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
		send_item('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
		send_item('{-1, -1, -1, -1, -1, -1, -1, -1});
		send_item('{0, 0, 0, 16, -1, 5, 1, 0});
		send_item('{0, 0, 0, 32, -1, 5, 1, 0});
	endtask

	// Near-parallel pairs around the threshold, then random ones.
	task automatic test_epsilon(input logic [31:0] eps);
		wait_idle();
		write_reg(EPS_ADDR, eps);
		send_item('{0, 0, ONE, 0, 0, -ONE, ONE, 1});
		send_item('{0, 0, 16, 0, 0, -ONE, 16, 32});
		send_item('{0, 0, 1, 0, 0, -1, 1, 1});
		send_item('{0, 0, 2, 4, -2, 5, 1, 2});
		repeat (40) send_item(aimed_item(32'h0000_4000));
	endtask

	task automatic test_random(input int count);
		repeat (count) begin
			if ($urandom_range(0, 4) == 0)
				send_item('{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), rand_coord(), rand_coord()});
			else if ($urandom_range(0, 1) == 0)
				send_item(aimed_item(32'h0FFF_FFFF));
			else
				send_item(aimed_item($urandom_range(4, 32'h0010_0000)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		item.valid = 1'b0;
		item.seg_start_x = '0; item.seg_start_y = '0; item.seg_end_x = '0;
		item.seg_end_y = '0; item.ray_origin_x = '0; item.ray_origin_y = '0;
		item.ray_dir_x = '0; item.ray_dir_y = '0;
		result.ready = 1'b0;
		eps_copy = EPS_RESET;
		errors = 0; quiet_cycles = 0; stall_left = 0;
		idle_on = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_epsilon(32'd0);
		test_epsilon(32'hFFFF_FFFF);
		test_epsilon($urandom);
		wait_idle();
		write_reg(SPARE_ADDR, 32'h0000_0000);
		write_reg(EPS_ADDR, EPS_RESET);
		test_random(1200);
		idle_on = 1'b0;
		test_random(250);

		wait_idle();
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule

/* ray_segment_intersect_2d_top.f */
hdl/rsi_pkg.sv
hdl/rsi_if.sv
hdl/rsi_cfg.sv
hdl/rsi_cross.sv
hdl/rsi_div_stage.sv
hdl/rsi_point.sv
hdl/ray_segment_intersect_2d_top.sv
sim/tb_top.sv
